// File: hw/rtl/nsr_pkg.sv
package nsr_pkg;

  // field and register widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 24;
  localparam int OUT_W     = 16;

  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_SOURCE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_SOURCE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_DEST_WIDTH    = 2'd2;
  localparam cfg_idx_t REG_DEST_HEIGHT   = 2'd3;

  // register reset values
  localparam cfg_t RST_SOURCE_WIDTH  = 11'd320;
  localparam cfg_t RST_SOURCE_HEIGHT = 11'd200;
  localparam cfg_t RST_DEST_WIDTH    = 11'd184;
  localparam cfg_t RST_DEST_HEIGHT   = 11'd96;

  // RGB888 -> RGB565, low byte sent first on the wire so swap the bytes
  function automatic logic [OUT_W-1:0] pack_rgb565(input logic [PIX_W-1:0] pix);
    logic [OUT_W-1:0] rgb;
    rgb = {pix[23:19], pix[15:10], pix[7:3]};
    return {rgb[7:0], rgb[15:8]};
  endfunction

endpackage

// File: hw/rtl/nsr_in_if.sv
interface nsr_in_if;
  logic                      valid;
  logic                      ready;
  logic [nsr_pkg::PIX_W-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink (input valid, input source_pixel, output ready);
endinterface

// File: hw/rtl/nsr_out_if.sv
interface nsr_out_if;
  logic                      valid;
  logic                      ready;
  logic [nsr_pkg::OUT_W-1:0] out_pixel;
  logic                      frame_end;

  modport source (output valid, output out_pixel, output frame_end, input ready);
  modport sink (input valid, input out_pixel, input frame_end, output ready);
endinterface

// File: hw/rtl/nearest_scale_rgb565_stream.sv
// A selected source pixel passes through the s1 and res registers before it appears on pixel_out.
// Throughput: one source pixel per cycle while pixel_out is not stalled; the position counters and accumulators
// update in the cycle of the request, so consecutive pixels need no gap.
// Non-selected pixels are absorbed and give no output request.
// Reset (rst, synchronous): size registers to 320x200 -> 184x96, position state
// cleared, pipeline emptied. Any register write also restarts the frame.
module nearest_scale_rgb565_stream #(
  parameter int MAX_DIM = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsr_pkg::CFG_W-1:0]  cfg_data,
  nsr_in_if.sink                     pixel_in,
  nsr_out_if.source                  pixel_out
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int CMP_W = (DIM_W > nsr_pkg::CFG_W) ? DIM_W : nsr_pkg::CFG_W;
  localparam int ACC_W = DIM_W + 1;

  // clamp a size register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input nsr_pkg::cfg_t v);
    logic [CMP_W-1:0] e;
    e = CMP_W'(v);
    if (e == '0) return DIM_W'(1);
    if (e > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(e);
  endfunction

  // size registers
  nsr_pkg::cfg_t source_width;
  nsr_pkg::cfg_t source_height;
  nsr_pkg::cfg_t dest_width;
  nsr_pkg::cfg_t dest_height;

  // position state
  logic [POS_W-1:0] src_col;
  logic [POS_W-1:0] src_row;
  logic [DIM_W-1:0] dst_col;
  logic [DIM_W-1:0] dst_row;
  logic [DIM_W-1:0] col_accum;
  logic [DIM_W-1:0] row_accum;

  // pipeline registers
  logic                      s1_valid;
  logic [nsr_pkg::PIX_W-1:0] s1_pixel;
  logic                      s1_last;
  logic                      res_valid;
  logic [nsr_pkg::OUT_W-1:0] res_pixel;
  logic                      res_last;

  // effective sizes, downscale only
  logic [DIM_W-1:0] sw, sh, dw_raw, dh_raw, dw, dh;

  assign sw     = clamp_dim(source_width);
  assign sh     = clamp_dim(source_height);
  assign dw_raw = clamp_dim(dest_width);
  assign dh_raw = clamp_dim(dest_height);
  assign dw     = (dw_raw > sw) ? sw : dw_raw;
  assign dh     = (dh_raw > sh) ? sh : dh_raw;

  // handshake
  logic res_free, s1_ready, accept;

  assign res_free       = !res_valid || pixel_out.ready;
  assign s1_ready       = !s1_valid || res_free;
  assign pixel_in.ready = s1_ready;
  assign accept         = pixel_in.valid && s1_ready;

  // selection and frame-end flag
  logic col_sel, row_sel, frame_last;

  assign col_sel    = col_accum < dw;
  assign row_sel    = row_accum < dh;
  assign frame_last = (dst_col == dw - DIM_W'(1)) && (dst_row == dh - DIM_W'(1));

  // accumulator steps
  logic [ACC_W-1:0] col_sum, row_sum;
  logic [DIM_W-1:0] col_accum_next, row_accum_next;
  logic [DIM_W-1:0] src_col_inc, src_row_inc;
  logic             line_end, frame_wrap;

  assign col_sum        = ACC_W'(col_accum) + (col_sel ? ACC_W'(sw) : ACC_W'(0));
  assign col_accum_next = (col_sum >= ACC_W'(dw)) ? DIM_W'(col_sum - ACC_W'(dw)) : '0;
  assign row_sum        = ACC_W'(row_accum) + (row_sel ? ACC_W'(sh) : ACC_W'(0));
  assign row_accum_next = (row_sum >= ACC_W'(dh)) ? DIM_W'(row_sum - ACC_W'(dh)) : '0;
  assign src_col_inc    = DIM_W'(src_col) + DIM_W'(1);
  assign src_row_inc    = DIM_W'(src_row) + DIM_W'(1);
  assign line_end       = src_col_inc >= sw;
  assign frame_wrap     = src_row_inc >= sh;

  // size registers and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= nsr_pkg::RST_SOURCE_WIDTH;
      source_height <= nsr_pkg::RST_SOURCE_HEIGHT;
      dest_width    <= nsr_pkg::RST_DEST_WIDTH;
      dest_height   <= nsr_pkg::RST_DEST_HEIGHT;
      src_col       <= '0;
      src_row       <= '0;
      dst_col       <= '0;
      dst_row       <= '0;
      col_accum     <= '0;
      row_accum     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nsr_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        nsr_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        nsr_pkg::REG_DEST_WIDTH:    dest_width    <= cfg_data;
        nsr_pkg::REG_DEST_HEIGHT:   dest_height   <= cfg_data;
        default: ;
      endcase
      src_col   <= '0;
      src_row   <= '0;
      dst_col   <= '0;
      dst_row   <= '0;
      col_accum <= '0;
      row_accum <= '0;
    end else if (accept) begin
      if (line_end) begin
        src_col   <= '0;
        dst_col   <= '0;
        col_accum <= '0;
        if (frame_wrap) begin
          src_row   <= '0;
          dst_row   <= '0;
          row_accum <= '0;
        end else begin
          src_row   <= POS_W'(src_row_inc);
          dst_row   <= dst_row + DIM_W'(row_sel);
          row_accum <= row_accum_next;
        end
      end else begin
        src_col   <= POS_W'(src_col_inc);
        dst_col   <= dst_col + DIM_W'(col_sel);
        col_accum <= col_accum_next;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= accept && col_sel && row_sel;
      end
      if (res_free) begin
        res_valid <= s1_valid;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_in.source_pixel;
      s1_last  <= frame_last;
    end
    if (res_free && s1_valid) begin
      res_pixel <= nsr_pkg::pack_rgb565(s1_pixel);
      res_last  <= s1_last;
    end
  end

  assign pixel_out.valid     = res_valid;
  assign pixel_out.out_pixel = res_pixel;
  assign pixel_out.frame_end = res_last;

  // accumulators stay below the source size
  a_col_accum: assert property (@(posedge clk) disable iff (rst) col_accum < sw)
    else $error("column accumulator out of range");
  a_row_accum: assert property (@(posedge clk) disable iff (rst) row_accum < sh)
    else $error("row accumulator out of range");
  // source position inside the frame
  a_src_pos: assert property (@(posedge clk) disable iff (rst)
    (DIM_W'(src_col) < sw) && (DIM_W'(src_row) < sh))
    else $error("source position outside frame");
  // never more output columns than the destination width
  a_dst_col: assert property (@(posedge clk) disable iff (rst) dst_col <= dw)
    else $error("destination column overrun");
  // a selected pixel always enters the pipeline
  a_sel_enter: assert property (@(posedge clk) disable iff (rst)
    accept && col_sel && row_sel |=> s1_valid)
    else $error("selected pixel lost");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_DIM       = 1024;
  localparam int IDLE_PCT      = 22;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [nsr_pkg::OUT_W-1:0] out_pixel;
    logic                      frame_end;
  } scaled_px_t;

  // Tracks the scaler position and holds the pixels still due on the output
  class downscale_model;
    nsr_pkg::cfg_t src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [10:0]   src_col, src_row, dst_col, dst_row;
    logic [20:0]   col_accum, row_accum;
    scaled_px_t    expected_px [$];
    int unsigned   errors;

    function new();
      src_w_reg = nsr_pkg::RST_SOURCE_WIDTH;
      src_h_reg = nsr_pkg::RST_SOURCE_HEIGHT;
      dst_w_reg = nsr_pkg::RST_DEST_WIDTH;
      dst_h_reg = nsr_pkg::RST_DEST_HEIGHT;
      errors    = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      src_col   = '0;
      src_row   = '0;
      dst_col   = '0;
      dst_row   = '0;
      col_accum = '0;
      row_accum = '0;
    endfunction

    function logic [10:0] clamp_dim(nsr_pkg::cfg_t v);
      if (v == 0) return 11'd1;
      if (v > MAX_DIM) return MAX_DIM[10:0];
      return v;
    endfunction

    function int unsigned pending();
      return expected_px.size();
    endfunction

    // any size write restarts the frame
    function void write_reg(nsr_pkg::cfg_idx_t idx, nsr_pkg::cfg_t val);
      case (idx)
        nsr_pkg::REG_SOURCE_WIDTH:  src_w_reg = val;
        nsr_pkg::REG_SOURCE_HEIGHT: src_h_reg = val;
        nsr_pkg::REG_DEST_WIDTH:    dst_w_reg = val;
        nsr_pkg::REG_DEST_HEIGHT:   dst_h_reg = val;
        default: ;
      endcase
      restart_frame();
    endfunction

    function void take_pixel(logic [nsr_pkg::PIX_W-1:0] pix);
      logic [10:0] sw, sh, dw, dh;
      logic [21:0] sum;
      logic [15:0] rgb;
      logic        col_hit, row_hit;
      scaled_px_t  px;
      sw = clamp_dim(src_w_reg);
      sh = clamp_dim(src_h_reg);
      dw = clamp_dim(dst_w_reg);
      dh = clamp_dim(dst_h_reg);
      // no upscaling
      if (dw > sw) dw = sw;
      if (dh > sh) dh = sh;
      col_hit = col_accum < dw;
      row_hit = row_accum < dh;

      if (col_hit && row_hit) begin
        rgb          = {pix[23:19], pix[15:10], pix[7:3]};
        px.out_pixel = {rgb[7:0], rgb[15:8]};
        px.frame_end = (dst_col == dw - 11'd1) && (dst_row == dh - 11'd1);
        expected_px.push_back(px);
      end

      // column step, accumulator floored at zero
      sum = {1'b0, col_accum};
      if (col_hit) begin
        dst_col++;
        sum = sum + sw;
      end
      sum       = (sum >= dw) ? sum - dw : '0;
      col_accum = sum[20:0];
      src_col++;

      // end of source line
      if (src_col >= sw) begin
        src_col   = '0;
        dst_col   = '0;
        col_accum = '0;
        sum       = {1'b0, row_accum};
        if (row_hit) begin
          dst_row++;
          sum = sum + sh;
        end
        sum       = (sum >= dh) ? sum - dh : '0;
        row_accum = sum[20:0];
        src_row++;
        if (src_row >= sh) begin
          src_row   = '0;
          dst_row   = '0;
          row_accum = '0;
        end
      end
    endfunction

    function void check_out(logic [nsr_pkg::OUT_W-1:0] pix, logic fend);
      scaled_px_t want;
      if (expected_px.size() == 0) begin
        $error("out_pixel: none expected, got %h (frame_end %b)", pix, fend);
        errors++;
        return;
      end
      want = expected_px.pop_front();
      if (pix !== want.out_pixel) begin
        $error("out_pixel: expected %h, got %h", want.out_pixel, pix);
        errors++;
      end
      if (fend !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, fend);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  nsr_pkg::cfg_idx_t cfg_index;
  nsr_pkg::cfg_t     cfg_data;
  logic              steady;
  int unsigned       cycles = 0;

  logic [nsr_pkg::PIX_W-1:0] test_colours [10] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
    24'h070307, 24'hf8fcf8, 24'h555555, 24'haaaaaa, 24'h123456
  };

  downscale_model scaler;

  nsr_in_if  pix_in ();
  nsr_out_if pix_out ();

  nearest_scale_rgb565_stream #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel_in (pix_in.sink),
    .pixel_out(pix_out.source)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side back-pressure
  always @(posedge clk) begin
    pix_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) scaler.write_reg(cfg_index, cfg_data);
      if (pix_in.valid && pix_in.ready) scaler.take_pixel(pix_in.source_pixel);
      if (pix_out.valid && pix_out.ready)
        scaler.check_out(pix_out.out_pixel, pix_out.frame_end);
    end
  end

  // one source pixel request, with random gaps ahead of it
  task automatic push_pixel(input logic [nsr_pkg::PIX_W-1:0] pix);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid        <= 1'b1;
    pix_in.source_pixel <= pix;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
  endtask

  // hold the input until every due pixel is out and the pipe is empty
  task automatic drain_results();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (scaler.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_sizes(input nsr_pkg::cfg_t sw, input nsr_pkg::cfg_t sh,
                               input nsr_pkg::cfg_t dw, input nsr_pkg::cfg_t dh,
                               input logic [3:0] mask);
    nsr_pkg::cfg_idx_t reg_ids [4];
    nsr_pkg::cfg_t     vals [4];
    reg_ids = '{nsr_pkg::REG_SOURCE_WIDTH, nsr_pkg::REG_SOURCE_HEIGHT,
                nsr_pkg::REG_DEST_WIDTH, nsr_pkg::REG_DEST_HEIGHT};
    vals    = '{sw, sh, dw, dh};
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= reg_ids[i];
        cfg_data  <= vals[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned   random_sent;
    int unsigned   phase;
    int unsigned   phase_items;
    int unsigned   pause_at;
    nsr_pkg::cfg_t sw, sh, dw, dh;
    logic [3:0]    mask;

    scaler = new();
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= nsr_pkg::REG_SOURCE_WIDTH;
    cfg_data            <= '0;
    steady              <= 1'b0;
    pix_in.valid        <= 1'b0;
    pix_in.source_pixel <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset sizes, colour extremes and truncation edges
    foreach (test_colours[i]) push_pixel(test_colours[i]);
    drain_results();

    // all sizes zero clamp to 1x1: every pixel closes a frame
    program_sizes('0, '0, '0, '0, 4'hf);
    repeat (3) push_pixel(nsr_pkg::PIX_W'($urandom()));
    drain_results();

    // destination above source is clamped to 2x2
    program_sizes(11'd2, 11'd2, 11'd5, 11'd7, 4'hf);
    repeat (5) push_pixel(nsr_pkg::PIX_W'($urandom()));
    drain_results();

    // largest sizes, clamping from the top
    program_sizes(11'd2047, 11'd1, 11'd1024, 11'd0, 4'hf);
    repeat (60) push_pixel(nsr_pkg::PIX_W'($urandom()));
    drain_results();
    program_sizes(11'd1024, 11'd1024, 11'd1024, 11'd1024, 4'hf);
    repeat (40) push_pixel(nsr_pkg::PIX_W'($urandom()));
    drain_results();
    program_sizes(11'd1, 11'd2047, 11'd1, 11'd1, 4'hf);
    repeat (40) push_pixel(nsr_pkg::PIX_W'($urandom()));
    drain_results();

    // small random frames, partial rewrites restart mid-frame
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      sw = nsr_pkg::cfg_t'($urandom_range(1, 16));
      sh = nsr_pkg::cfg_t'($urandom_range(1, 10));
      dw = nsr_pkg::cfg_t'($urandom_range(0, sw + 2));
      dh = nsr_pkg::cfg_t'($urandom_range(0, sh + 2));
      if ($urandom_range(0, 9) == 0) dw = 11'd2047;
      if ($urandom_range(0, 9) == 0) dh = 11'd2047;
      mask = (phase == 0) ? 4'hf : 4'($urandom_range(1, 15));
      program_sizes(sw, sh, dw, dh, mask);

      if (phase == 3) steady <= 1'b1;
      phase_items = $urandom_range(30, 120);
      pause_at    = $urandom_range(0, phase_items - 1);
      for (int n = 0; n < phase_items; n++) begin
        if (n == pause_at) drain_results();
        push_pixel(nsr_pkg::PIX_W'($urandom()));
      end
      random_sent += phase_items;
      drain_results();
      steady <= 1'b0;
      phase++;
    end

    if (scaler.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
